### hw/rtl/srs_pkg.sv
// shared types and constants for the scrub region scheduler
`timescale 1ns / 1ps
`default_nettype none

package srs_pkg;

    localparam int SLOTS      = 8;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int CFG_ADDR_W = 3;

    localparam logic [31:0] FALLBACK_INTERVAL = 32'd1000;
    localparam logic [31:0] DEFAULT_INTERVAL_RST = 32'd1000;

    // request codes
    localparam logic [2:0] REQ_REGISTER     = 3'd0;
    localparam logic [2:0] REQ_UNREGISTER   = 3'd1;
    localparam logic [2:0] REQ_SET_ENABLE   = 3'd2;
    localparam logic [2:0] REQ_SET_INTERVAL = 3'd3;
    localparam logic [2:0] REQ_PICK         = 3'd4;

    // register index, taken from paddr[2]
    localparam logic REG_DEFAULT_INTERVAL = 1'b0;
    localparam logic REG_MONITOR_RUNNING  = 1'b1;

    typedef struct packed {
        logic [31:0] default_interval;
        logic        monitor_running;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] region_key;
        logic [7:0]  prio_level;
        logic [31:0] period_ms;
        logic        enable_bit;
        logic [31:0] now_ms;
    } item_t;

    typedef struct packed {
        logic        ok;
        logic        picked_valid;
        logic [2:0]  picked_slot;
        logic [15:0] picked_key;
        logic [3:0]  region_total;
        logic [3:0]  region_active;
        logic        overflow_seen;
    } res_t;

    typedef struct packed {
        logic [15:0] key;
        logic        en;
        logic [7:0]  prio;
        logic [31:0] interval;
        logic [31:0] last_scan;
        logic [31:0] visit_count;
    } rec_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
    } tbl_rd_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic              valid;
        rec_t              rec;
    } tbl_wr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } ctrl_state_t;

endpackage

`default_nettype wire

### hw/rtl/scrub_region_scheduler_unit.sv
// Scrub region scheduler: table of scrub regions with register, unregister,
// enable, interval and pick requests.
//
// Input channel in_valid/in_stall carries one request item; the result item
// leaves on out_valid/out_stall, one result for every request.
// Each item reads the slot table once from the record memory, one slot per
// cycle through its single read port, then writes back the target slot.
// An item is taken in the idle state, scanned slot by slot in the scan state
// and finished in the update state, which registers its result; the next
// item is taken once the block is back in the idle state.
// The result sits in an output register, so the next item is taken and
// scanned while an earlier result waits; if the receiver still stalls when
// the next result is ready, the block holds that item in its write-back step
// and stalls the input until the output register frees.
// Reset empties all slots (occupancy bits clear at once), zeroes the counts
// and the overflow flag, sets default_interval to 1000 and stops monitoring.
// Configuration registers: default_interval at 0x0, monitor_running at 0x4.
`timescale 1ns / 1ps
`default_nettype none

module scrub_region_scheduler_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [srs_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [2:0]                     req_type,
    input  wire logic [15:0]                    region_key,
    input  wire logic [7:0]                     prio_level,
    input  wire logic [31:0]                    period_ms,
    input  wire logic                           enable_bit,
    input  wire logic [31:0]                    now_ms,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                ok,
    output logic                                picked_valid,
    output logic [2:0]                          picked_slot,
    output logic [15:0]                         picked_key,
    output logic [3:0]                          region_total,
    output logic [3:0]                          region_active,
    output logic                                overflow_seen
);
    import srs_pkg::*;

    cfg_t    cfg;
    item_t   item;
    res_t    res;
    tbl_rd_t rd;
    tbl_wr_t wr;
    rec_t    rd_rec;
    logic    rd_valid;

    assign item.req_type   = req_type;
    assign item.region_key = region_key;
    assign item.prio_level = prio_level;
    assign item.period_ms  = period_ms;
    assign item.enable_bit = enable_bit;
    assign item.now_ms     = now_ms;

    srs_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    srs_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd       (rd),
        .wr       (wr),
        .rd_rec   (rd_rec),
        .rd_valid (rd_valid)
    );

    srs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .item      (item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res),
        .rd        (rd),
        .wr        (wr),
        .rd_rec    (rd_rec),
        .rd_valid  (rd_valid)
    );

    assign ok            = res.ok;
    assign picked_valid  = res.picked_valid;
    assign picked_slot   = res.picked_slot;
    assign picked_key    = res.picked_key;
    assign region_total  = res.region_total;
    assign region_active = res.region_active;
    assign overflow_seen = res.overflow_seen;

endmodule

`default_nettype wire

### hw/rtl/srs_cfg_regs.sv
// configuration registers behind the apb port
`timescale 1ns / 1ps
`default_nettype none

module srs_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [srs_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output srs_pkg::cfg_t                      cfg
);
    import srs_pkg::*;

    logic [31:0] default_interval_reg;
    logic        monitor_running_reg;
    logic        wr_en;
    logic        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_interval_reg <= DEFAULT_INTERVAL_RST;
            monitor_running_reg  <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_DEFAULT_INTERVAL: default_interval_reg <= pwdata;
                REG_MONITOR_RUNNING:  monitor_running_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_DEFAULT_INTERVAL: prdata = default_interval_reg;
            REG_MONITOR_RUNNING:  prdata = {31'd0, monitor_running_reg};
            default:              prdata = 32'd0;
        endcase
    end

    assign cfg.default_interval = default_interval_reg;
    assign cfg.monitor_running  = monitor_running_reg;

endmodule

`default_nettype wire

### hw/rtl/srs_table.sv
// region table: slot record memory with occupancy bits
`timescale 1ns / 1ps
`default_nettype none

module srs_table (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire srs_pkg::tbl_rd_t rd,
    input  wire srs_pkg::tbl_wr_t wr,
    output srs_pkg::rec_t         rd_rec,
    output logic                  rd_valid
);
    import srs_pkg::*;

    rec_t             mem [SLOTS];
    logic [SLOTS-1:0] occ_reg;
    rec_t             rd_data_reg;
    logic             rd_occ_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.rec;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg    <= '0;
            rd_occ_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                occ_reg[wr.addr] <= wr.valid;
            end
            if (rd.en)
            begin
                rd_occ_reg <= occ_reg[rd.addr];
            end
        end
    end

    // an empty slot reads as all zero
    assign rd_valid = rd_occ_reg;
    assign rd_rec   = rd_occ_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

### hw/rtl/srs_ctrl.sv
// request sequencer: table scan, read-modify-write and result register
`timescale 1ns / 1ps
`default_nettype none

module srs_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire srs_pkg::cfg_t  cfg,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire srs_pkg::item_t item,
    output logic                out_valid,
    input  wire logic           out_stall,
    output srs_pkg::res_t       res,
    output srs_pkg::tbl_rd_t    rd,
    output srs_pkg::tbl_wr_t    wr,
    input  wire srs_pkg::rec_t  rd_rec,
    input  wire logic           rd_valid
);
    import srs_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    ctrl_state_t       state_reg, state_next;
    item_t             item_reg, item_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              sel_found_reg, sel_found_next;
    logic [SLOT_W-1:0] sel_slot_reg, sel_slot_next;
    logic [7:0]        sel_prio_reg, sel_prio_next;
    rec_t              sel_rec_reg, sel_rec_next;
    logic              free_found_reg, free_found_next;
    logic [SLOT_W-1:0] free_slot_reg, free_slot_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  active_reg, active_next;
    logic              overflow_reg, overflow_next;
    logic              out_valid_reg, out_valid_next;
    res_t              res_reg, res_next;

    logic              out_free;
    logic              due;
    logic              pick_cand;
    logic              match_cand;
    logic              key_nz;
    logic [31:0]       ivl_eff;
    logic              ok_w, pv_w;
    rec_t              wr_rec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            active_reg    <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            active_reg    <= active_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        idx_reg        <= idx_next;
        sel_found_reg  <= sel_found_next;
        sel_slot_reg   <= sel_slot_next;
        sel_prio_reg   <= sel_prio_next;
        sel_rec_reg    <= sel_rec_next;
        free_found_reg <= free_found_next;
        free_slot_reg  <= free_slot_next;
        res_reg        <= res_next;
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign key_nz   = item_reg.region_key != 16'd0;

    // wrapped elapsed time against the slot interval
    assign due        = (item_reg.now_ms - rd_rec.last_scan) >= rd_rec.interval;
    assign pick_cand  = rd_valid && rd_rec.en && due && (rd_rec.prio > sel_prio_reg);
    assign match_cand = rd_valid && key_nz && (rd_rec.key == item_reg.region_key)
                        && !sel_found_reg;

    always_comb
    begin
        if (item_reg.period_ms != 32'd0)
        begin
            ivl_eff = item_reg.period_ms;
        end
        else if (cfg.default_interval != 32'd0)
        begin
            ivl_eff = cfg.default_interval;
        end
        else
        begin
            ivl_eff = FALLBACK_INTERVAL;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        idx_next        = idx_reg;
        sel_found_next  = sel_found_reg;
        sel_slot_next   = sel_slot_reg;
        sel_prio_next   = sel_prio_reg;
        sel_rec_next    = sel_rec_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        total_next      = total_reg;
        active_next     = active_reg;
        overflow_next   = overflow_reg;
        out_valid_next  = out_valid_reg && out_stall;
        res_next        = res_reg;
        in_stall        = 1'b1;
        rd.en           = 1'b0;
        rd.addr         = '0;
        wr.en           = 1'b0;
        wr.addr         = sel_slot_reg;
        wr.valid        = 1'b1;
        wr_rec          = sel_rec_reg;
        ok_w            = 1'b0;
        pv_w            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                rd.en    = in_valid;
                rd.addr  = '0;
                if (in_valid)
                begin
                    item_next       = item;
                    idx_next        = '0;
                    sel_found_next  = 1'b0;
                    sel_slot_next   = '0;
                    sel_prio_next   = 8'd0;
                    free_found_next = 1'b0;
                    free_slot_next  = '0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // read the next slot while the current one is evaluated
                rd.en   = idx_reg != LAST_SLOT;
                rd.addr = idx_reg + SLOT_W'(1);
                if ((item_reg.req_type == REQ_PICK) ? pick_cand : match_cand)
                begin
                    sel_found_next = 1'b1;
                    sel_slot_next  = idx_reg;
                    sel_prio_next  = rd_rec.prio;
                    sel_rec_next   = rd_rec;
                end
                if (!rd_valid && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_slot_next  = idx_reg;
                end
                idx_next = idx_reg + SLOT_W'(1);
                if (idx_reg == LAST_SLOT)
                begin
                    state_next = ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                if (out_free)
                begin
                    case (item_reg.req_type)
                        REQ_REGISTER:
                        begin
                            if (key_nz && !sel_found_reg)
                            begin
                                if (!free_found_reg)
                                begin
                                    overflow_next = 1'b1;
                                end
                                else
                                begin
                                    wr.en              = 1'b1;
                                    wr.addr            = free_slot_reg;
                                    wr_rec.key         = item_reg.region_key;
                                    wr_rec.en          = item_reg.enable_bit;
                                    wr_rec.prio        = item_reg.prio_level;
                                    wr_rec.interval    = ivl_eff;
                                    wr_rec.last_scan   = 32'd0;
                                    wr_rec.visit_count = 32'd0;
                                    total_next         = total_reg + CNT_W'(1);
                                    if (item_reg.enable_bit)
                                    begin
                                        active_next = active_reg + CNT_W'(1);
                                    end
                                    ok_w = 1'b1;
                                end
                            end
                        end

                        REQ_UNREGISTER:
                        begin
                            if (sel_found_reg)
                            begin
                                wr.en    = 1'b1;
                                wr.valid = 1'b0;
                                wr_rec   = '0;
                                if (sel_rec_reg.en && active_reg != '0)
                                begin
                                    active_next = active_reg - CNT_W'(1);
                                end
                                if (total_reg != '0)
                                begin
                                    total_next = total_reg - CNT_W'(1);
                                end
                                ok_w = 1'b1;
                            end
                        end

                        REQ_SET_ENABLE:
                        begin
                            if (sel_found_reg)
                            begin
                                wr.en     = 1'b1;
                                wr_rec.en = item_reg.enable_bit;
                                if (sel_rec_reg.en != item_reg.enable_bit)
                                begin
                                    if (item_reg.enable_bit)
                                    begin
                                        active_next = active_reg + CNT_W'(1);
                                    end
                                    else if (active_reg != '0)
                                    begin
                                        active_next = active_reg - CNT_W'(1);
                                    end
                                end
                                ok_w = 1'b1;
                            end
                        end

                        REQ_SET_INTERVAL:
                        begin
                            if (sel_found_reg)
                            begin
                                wr.en           = 1'b1;
                                wr_rec.interval = item_reg.period_ms;
                                ok_w            = 1'b1;
                            end
                        end

                        REQ_PICK:
                        begin
                            if (cfg.monitor_running)
                            begin
                                ok_w = 1'b1;
                                if (sel_found_reg)
                                begin
                                    wr.en              = 1'b1;
                                    wr_rec.last_scan   = item_reg.now_ms;
                                    wr_rec.visit_count = sel_rec_reg.visit_count + 32'd1;
                                    pv_w               = 1'b1;
                                end
                            end
                        end

                        default: ;
                    endcase

                    res_next.ok            = ok_w;
                    res_next.picked_valid  = pv_w;
                    res_next.picked_slot   = pv_w ? 3'(sel_slot_reg) : 3'd0;
                    res_next.picked_key    = pv_w ? sel_rec_reg.key : 16'd0;
                    res_next.region_total  = 4'(total_next);
                    res_next.region_active = 4'(active_next);
                    res_next.overflow_seen = overflow_next;
                    out_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        wr.rec = wr_rec;
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire
